### src/accmag_pkg.sv
`default_nettype none

package accmag_pkg;

    localparam int AXES_W     = 2;
    localparam int WIN_LEN_W  = 7;
    localparam int THR_W      = 12;
    localparam int HOLD_W     = 32;
    localparam int TIME_W     = 32;
    localparam int FILT_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int M_TDATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_AXES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS     = 2'd3;

    localparam logic [AXES_W-1:0]    RST_ACTIVE_AXES = 2'd3;
    localparam logic [WIN_LEN_W-1:0] RST_WINDOW_LEN  = 7'd16;
    localparam logic [THR_W-1:0]     RST_THRESHOLD   = 12'd50;
    localparam logic [HOLD_W-1:0]    RST_HOLD_MS     = 32'd500;

    typedef enum logic [1:0] {
        CS_SQRT = 2'b01,
        CS_DIV  = 2'b10
    } cs_mode_t;

    typedef struct packed {
        logic     start;
        cs_mode_t mode;
    } cs_ctrl_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SQUARE = 6'b000010,
        S_SQRT   = 6'b000100,
        S_TOTAL  = 6'b001000,
        S_DIV    = 6'b010000,
        S_JUDGE  = 6'b100000
    } seq_state_t;

endpackage

`default_nettype wire

### src/accel_magnitude_tap_detector_unit.sv
// Tap detector for a three-axis accelerometer stream.
// Each s_ transfer carries three axis samples and a millisecond timestamp. The block squares
// and sums the active axes, takes the integer square root, keeps a ring of the last
// window_len magnitudes and subtracts their floored average. Every window_len samples the
// filtered value is compared with the threshold to set or hold the detected status, which
// clears once more than hold_ms has passed since the last detection.
// Each input transfer produces exactly one m_ transfer.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata; the user must write
// it only while no sample is in flight, which the block does not enforce. A write to
// window_len empties the ring and restarts the window. The shared compare-subtract unit
// produces one root bit and then one quotient bit per cycle while busy, and s_tready stays
// low until the sample has passed the judge state.
// A finished result waits in an output register, and s_tready rises again meanwhile; a
// following result waits only if the previous one has not yet been taken.
// Reset restores the register defaults, empties the ring and clears the detection status.
`default_nettype none

module accel_magnitude_tap_detector_unit #(
    parameter int  MAX_WINDOW  = 64,
    parameter int  MAX_AXES    = 3,
    parameter int  SAMPLE_BITS = 10,
    localparam int S_TDATA_W   = ((3 * SAMPLE_BITS + accmag_pkg::TIME_W + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [accmag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [accmag_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0 up: axis_x, axis_y, axis_z, now_ms, zero fill.
    input  logic [S_TDATA_W-1:0]              s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0 up: filtered_mag, detected, detect_event, zero fill.
    output logic [accmag_pkg::M_TDATA_W-1:0]  m_tdata,
    // Field: evaluated.
    output logic [0:0]                        m_tuser
);

    localparam int SB     = SAMPLE_BITS;
    localparam int MAG_W  = SB + 1;
    localparam int POS_W  = $clog2(MAX_WINDOW);
    localparam int NW     = $clog2(MAX_WINDOW + 1);
    localparam int TOT_W  = MAG_W + POS_W;
    localparam int SUM_W  = 2 * MAG_W;
    localparam int SQ_W   = 2 * SB;
    localparam int CS_W   = (SUM_W > TOT_W) ? SUM_W : TOT_W;
    localparam int FW     = accmag_pkg::FILT_W;
    localparam int DIFF_W = (MAG_W + 2 > FW + 1) ? MAG_W + 2 : FW + 1;
    localparam int TW     = accmag_pkg::TIME_W;

    localparam logic signed [DIFF_W-1:0] FILT_MAX = DIFF_W'((1 << (FW - 1)) - 1);
    localparam logic signed [DIFF_W-1:0] FILT_MIN = -DIFF_W'(1 << (FW - 1));

    accmag_pkg::seq_state_t state_reg;

    logic [accmag_pkg::AXES_W-1:0]    axes_reg;
    logic [accmag_pkg::WIN_LEN_W-1:0] win_len_reg;
    logic [accmag_pkg::THR_W-1:0]     thr_reg;
    logic [accmag_pkg::HOLD_W-1:0]    hold_reg;

    logic [SB-1:0]    ax_x_reg;
    logic [SB-1:0]    ax_y_reg;
    logic [SB-1:0]    ax_z_reg;
    logic [TW-1:0]    now_reg;
    logic [1:0]       a_reg;
    logic [SQ_W-1:0]  prod_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [MAG_W-1:0] mag_reg;
    logic [MAG_W-1:0] avg_reg;
    logic [TOT_W-1:0] total_reg;
    logic [POS_W-1:0] pos_reg;
    logic             wrapped_reg;
    logic             status_reg;
    logic             status_prev_reg;
    logic [TW-1:0]    last_time_reg;
    logic [FW-1:0]    last_filt_reg;

    logic                            m_tvalid_reg;
    logic [accmag_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                            m_tuser_reg;

    logic [1:0]       axes_eff;
    logic [31:0]      win_ext;
    logic [NW-1:0]    n_eff;
    logic [SB-1:0]    ax_sel;
    logic [SQ_W-1:0]  sq;
    logic [SUM_W-1:0] sum_final;
    logic [MAG_W-1:0] ring_rdata;
    logic [MAG_W-1:0] old_mag;
    logic [TOT_W-1:0] total_next;
    logic             in_xfer;
    logic             out_free;

    accmag_pkg::cs_ctrl_t cs_ctrl;
    logic [CS_W-1:0]      cs_opa;
    logic                 cs_done;
    logic [CS_W-1:0]      cs_result;
    logic                 ring_we;

    logic signed [DIFF_W-1:0] diff;
    logic [FW-1:0]            filt;
    logic signed [FW-1:0]     thr_s;
    logic [NW-1:0]            pos_inc;
    logic                     eval;
    logic                     st_new;
    logic [TW-1:0]            lt_new;
    logic [TW-1:0]            elapsed;
    logic                     ev;

    always_comb begin
        if (axes_reg == 2'd0) begin
            axes_eff = 2'd1;
        end else if (32'(axes_reg) > 32'(MAX_AXES)) begin
            axes_eff = 2'(MAX_AXES);
        end else begin
            axes_eff = axes_reg;
        end

        win_ext = 32'(win_len_reg);
        if (win_len_reg == '0) begin
            n_eff = NW'(1);
        end else if (win_ext > 32'(MAX_WINDOW)) begin
            n_eff = NW'(MAX_WINDOW);
        end else begin
            n_eff = win_ext[NW-1:0];
        end

        case (a_reg)
            2'd0:    ax_sel = ax_x_reg;
            2'd1:    ax_sel = ax_y_reg;
            2'd2:    ax_sel = ax_z_reg;
            default: ax_sel = '0;
        endcase
    end

    assign sq         = SQ_W'(ax_sel) * SQ_W'(ax_sel);
    assign sum_final  = sum_reg + SUM_W'(prod_reg);
    assign old_mag    = wrapped_reg ? ring_rdata : '0;
    assign total_next = total_reg - TOT_W'(old_mag) + TOT_W'(mag_reg);
    assign in_xfer    = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;

    always_comb begin
        cs_ctrl.start = ((state_reg == accmag_pkg::S_SQUARE) && (a_reg == axes_eff))
                        || (state_reg == accmag_pkg::S_TOTAL);
        cs_ctrl.mode  = (state_reg == accmag_pkg::S_TOTAL) ? accmag_pkg::CS_DIV
                                                           : accmag_pkg::CS_SQRT;
        cs_opa        = (state_reg == accmag_pkg::S_TOTAL) ? CS_W'(total_next)
                                                           : CS_W'(sum_final);
    end

    assign ring_we = (state_reg == accmag_pkg::S_SQRT) && cs_done;

    always_comb begin
        diff = DIFF_W'(mag_reg) - DIFF_W'(avg_reg);
        if (diff > FILT_MAX) begin
            filt = FILT_MAX[FW-1:0];
        end else if (diff < FILT_MIN) begin
            filt = FILT_MIN[FW-1:0];
        end else begin
            filt = diff[FW-1:0];
        end

        pos_inc = NW'(pos_reg) + NW'(1);
        eval    = (pos_inc >= n_eff);
        thr_s   = thr_reg;

        st_new = status_reg;
        lt_new = last_time_reg;
        if ($signed(filt) > thr_s) begin
            st_new = 1'b1;
            lt_new = now_reg;
        end
        elapsed = now_reg - lt_new;
        if ((lt_new != '0) && (elapsed > hold_reg)) begin
            st_new = 1'b0;
        end
        ev = st_new && !status_prev_reg;
    end

    accmag_cs_unit #(
        .DATA_W (CS_W),
        .ROOT_W (MAG_W),
        .RAD_W  (SUM_W),
        .TOT_W  (TOT_W),
        .DIV_W  (NW)
    ) u_cs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (cs_ctrl),
        .opa     (cs_opa),
        .divisor (n_eff),
        .done    (cs_done),
        .result  (cs_result)
    );

    accmag_ring #(
        .DEPTH  (MAX_WINDOW),
        .DATA_W (MAG_W),
        .ADDR_W (POS_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ring_we),
        .wr_addr (pos_reg),
        .wr_data (cs_result[MAG_W-1:0]),
        .rd_en   (in_xfer),
        .rd_addr (pos_reg),
        .rd_data (ring_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= accmag_pkg::S_IDLE;
            axes_reg        <= accmag_pkg::RST_ACTIVE_AXES;
            win_len_reg     <= accmag_pkg::RST_WINDOW_LEN;
            thr_reg         <= accmag_pkg::RST_THRESHOLD;
            hold_reg        <= accmag_pkg::RST_HOLD_MS;
            total_reg       <= '0;
            pos_reg         <= '0;
            wrapped_reg     <= 1'b0;
            status_reg      <= 1'b0;
            status_prev_reg <= 1'b0;
            last_time_reg   <= '0;
            last_filt_reg   <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                accmag_pkg::S_IDLE: begin
                    if (s_tvalid) begin
                        ax_x_reg  <= s_tdata[SB-1:0];
                        ax_y_reg  <= s_tdata[2*SB-1:SB];
                        ax_z_reg  <= s_tdata[3*SB-1:2*SB];
                        now_reg   <= s_tdata[3*SB+TW-1:3*SB];
                        a_reg     <= 2'd0;
                        prod_reg  <= '0;
                        sum_reg   <= '0;
                        state_reg <= accmag_pkg::S_SQUARE;
                    end
                end
                accmag_pkg::S_SQUARE: begin
                    sum_reg  <= sum_final;
                    prod_reg <= (a_reg < axes_eff) ? sq : '0;
                    a_reg    <= a_reg + 2'd1;
                    if (a_reg == axes_eff) begin
                        state_reg <= accmag_pkg::S_SQRT;
                    end
                end
                accmag_pkg::S_SQRT: begin
                    if (cs_done) begin
                        mag_reg   <= cs_result[MAG_W-1:0];
                        state_reg <= accmag_pkg::S_TOTAL;
                    end
                end
                accmag_pkg::S_TOTAL: begin
                    total_reg <= total_next;
                    state_reg <= accmag_pkg::S_DIV;
                end
                accmag_pkg::S_DIV: begin
                    if (cs_done) begin
                        avg_reg   <= cs_result[MAG_W-1:0];
                        state_reg <= accmag_pkg::S_JUDGE;
                    end
                end
                accmag_pkg::S_JUDGE: begin
                    if (out_free) begin
                        m_tuser_reg  <= eval;
                        if (eval) begin
                            m_tdata_reg     <= {2'b00, ev, st_new, filt};
                            status_reg      <= st_new;
                            status_prev_reg <= st_new;
                            last_time_reg   <= lt_new;
                            last_filt_reg   <= filt;
                            pos_reg         <= '0;
                            wrapped_reg     <= 1'b1;
                        end else begin
                            m_tdata_reg <= {2'b00, 1'b0, status_reg, last_filt_reg};
                            pos_reg     <= pos_inc[POS_W-1:0];
                        end
                        state_reg <= accmag_pkg::S_IDLE;
                    end
                end
                default: begin
                    state_reg <= accmag_pkg::S_IDLE;
                end
            endcase

            if ((state_reg == accmag_pkg::S_JUDGE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                unique case (cfg_index)
                    accmag_pkg::REG_ACTIVE_AXES: begin
                        axes_reg <= cfg_wdata[accmag_pkg::AXES_W-1:0];
                    end
                    accmag_pkg::REG_WINDOW_LEN: begin
                        win_len_reg <= cfg_wdata[accmag_pkg::WIN_LEN_W-1:0];
                        total_reg   <= '0;
                        pos_reg     <= '0;
                        wrapped_reg <= 1'b0;
                    end
                    accmag_pkg::REG_THRESHOLD: begin
                        thr_reg <= cfg_wdata[accmag_pkg::THR_W-1:0];
                    end
                    accmag_pkg::REG_HOLD_MS: begin
                        hold_reg <= cfg_wdata[accmag_pkg::HOLD_W-1:0];
                    end
                    default: begin
                        hold_reg <= hold_reg;
                    end
                endcase
            end
        end
    end

    assign s_tready = (state_reg == accmag_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    a_pos_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        NW'(pos_reg) < n_eff)
        else $error("ring position is outside the window");

    a_event_needs_detect: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[FW+1]) |-> (m_tdata[FW] && m_tuser[0]))
        else $error("detect event without a judged detection");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cs_done |-> ((state_reg == accmag_pkg::S_SQRT) || (state_reg == accmag_pkg::S_DIV)))
        else $error("arithmetic unit finished outside a wait state");

    a_result_from_judge: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == accmag_pkg::S_JUDGE))
        else $error("result loaded outside the judge state");
`endif

endmodule

`default_nettype wire

### src/accmag_ring.sv
`default_nettype none

module accmag_ring #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 11,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### src/accmag_cs_unit.sv
`default_nettype none

module accmag_cs_unit #(
    parameter int DATA_W = 22,
    parameter int ROOT_W = 11,
    parameter int RAD_W  = 22,
    parameter int TOT_W  = 17,
    parameter int DIV_W  = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  accmag_pkg::cs_ctrl_t ctrl,
    input  logic [DATA_W-1:0]    opa,
    input  logic [DIV_W-1:0]     divisor,
    output logic                 done,
    output logic [DATA_W-1:0]    result
);

    localparam int STEPS_MAX = (ROOT_W > TOT_W) ? ROOT_W : TOT_W;
    localparam int CNT_W     = $clog2(STEPS_MAX + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    accmag_pkg::cs_mode_t mode_reg;
    logic [DATA_W-1:0]    dat_reg;
    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W-1:0]    q_reg;
    logic [DIV_W-1:0]     div_reg;

    logic [DATA_W-1:0] rem_sh;
    logic [DATA_W-1:0] trial;
    logic              fits;

    always_comb begin
        if (mode_reg == accmag_pkg::CS_SQRT) begin
            rem_sh = {rem_reg[DATA_W-3:0], dat_reg[DATA_W-1 -: 2]};
            trial  = {q_reg[DATA_W-3:0], 2'b01};
        end else begin
            rem_sh = {rem_reg[DATA_W-2:0], dat_reg[DATA_W-1]};
            trial  = DATA_W'(div_reg);
        end
        fits = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (ctrl.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == CNT_W'(1))) begin
                busy_reg <= 1'b0;
            end
        end

        if (ctrl.start) begin
            mode_reg <= ctrl.mode;
            div_reg  <= divisor;
            rem_reg  <= '0;
            q_reg    <= '0;
            if (ctrl.mode == accmag_pkg::CS_SQRT) begin
                dat_reg <= opa << (DATA_W - RAD_W);
                cnt_reg <= CNT_W'(ROOT_W);
            end else begin
                dat_reg <= opa << (DATA_W - TOT_W);
                cnt_reg <= CNT_W'(TOT_W);
            end
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            rem_reg <= fits ? (rem_sh - trial) : rem_sh;
            q_reg   <= {q_reg[DATA_W-2:0], fits};
            if (mode_reg == accmag_pkg::CS_SQRT) begin
                dat_reg <= {dat_reg[DATA_W-3:0], 2'b00};
            end else begin
                dat_reg <= {dat_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign done   = done_reg;
    assign result = q_reg;

endmodule

`default_nettype wire
